@@ rtl/aed_pkg.sv @@
package aed_pkg;

  // channel and register widths
  localparam int CH_W       = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 16;
  // row position runs to height + 1 during the flush tail
  localparam int ROW_W      = 17;

  // neighbor accumulation: eight 8-bit terms, count 0..8
  localparam int NB_N       = 8;
  localparam int SUM_W      = 11;
  localparam int CNT_W      = 4;

  // mean by reciprocal: q = (sum * ceil(2^14 / n)) >> 14, exact for sum < 2048
  localparam int RECIP_W    = 15;
  localparam int RECIP_SH   = 14;

  localparam logic [IMG_W_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [IMG_H_W-1:0] HEIGHT_RST = 16'd480;
  localparam logic [CH_W-1:0]    THR_RST    = 8'd0;
  localparam logic [CH_W-1:0]    ALPHA_FULL = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH     = 2'd0,
    REG_IMAGE_HEIGHT    = 2'd1,
    REG_ALPHA_THRESHOLD = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MEAN
  } aed_state_t;

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pix_t;

  // one window column, rows top to bottom
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  // one line memory entry: two rows above the incoming one
  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } line_t;

  // border masks for the window being evaluated
  typedef struct packed {
    logic left_ok;
    logic right_ok;
    logic top_ok;
    logic bot_ok;
  } mask_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum_red;
    logic [SUM_W-1:0] sum_green;
    logic [SUM_W-1:0] sum_blue;
    logic [CNT_W-1:0] count;
    pix_t             center;
    logic             fill;
  } win_res_t;

  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] k;
    case (n)
      4'd1:    k = 15'd16384;
      4'd2:    k = 15'd8192;
      4'd3:    k = 15'd5462;
      4'd4:    k = 15'd4096;
      4'd5:    k = 15'd3277;
      4'd6:    k = 15'd2731;
      4'd7:    k = 15'd2341;
      4'd8:    k = 15'd2048;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/aed_if.sv @@
// pixel input channel
interface aed_in_if;
  logic                      valid;
  logic                      ready;
  logic [aed_pkg::CH_W-1:0]  red;
  logic [aed_pkg::CH_W-1:0]  green;
  logic [aed_pkg::CH_W-1:0]  blue;
  logic [aed_pkg::CH_W-1:0]  alpha;
  logic                      flush;

  modport source (output valid, red, green, blue, alpha, flush, input ready);
  modport sink   (input valid, red, green, blue, alpha, flush, output ready);
endinterface

// result channel
interface aed_out_if;
  logic                      valid;
  logic                      ready;
  logic [aed_pkg::CH_W-1:0]  out_red;
  logic [aed_pkg::CH_W-1:0]  out_green;
  logic [aed_pkg::CH_W-1:0]  out_blue;
  logic [aed_pkg::CH_W-1:0]  out_alpha;
  logic                      filled;
  logic                      frame_last;
  logic                      any_filled;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, filled,
                  frame_last, any_filled, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, filled,
                  frame_last, any_filled, output ready);
endinterface

// register write channel
interface aed_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [aed_pkg::CFG_IDX_W-1:0]   index;
  logic [aed_pkg::CFG_DATA_W-1:0]  wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

@@ rtl/aed_line_ram.sv @@
// simple dual-port line memory, registered read
module aed_line_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/aed_window.sv @@
// 3x3 window: two stored columns plus the column read this beat,
// masked neighbor accumulation and center test
module aed_window (
  input  logic                     clk,
  input  logic                     step,
  input  aed_pkg::col_t            new_col,
  input  aed_pkg::mask_t           mask,
  input  logic [aed_pkg::CH_W-1:0] threshold,
  output aed_pkg::win_res_t        res
);

  aed_pkg::col_t    mid_col_r;
  aed_pkg::col_t    right_col_r;
  aed_pkg::win_res_t res_r;

  aed_pkg::pix_t    nb     [aed_pkg::NB_N];
  logic             nb_ok  [aed_pkg::NB_N];
  aed_pkg::win_res_t res_nxt;

  // neighbor layout: left = old middle column, center = old right column,
  // right = column arriving from the line memory
  always_comb begin
    nb[0]    = mid_col_r.top;
    nb_ok[0] = mask.left_ok & mask.top_ok;
    nb[1]    = right_col_r.top;
    nb_ok[1] = mask.top_ok;
    nb[2]    = new_col.top;
    nb_ok[2] = mask.right_ok & mask.top_ok;
    nb[3]    = mid_col_r.mid;
    nb_ok[3] = mask.left_ok;
    nb[4]    = new_col.mid;
    nb_ok[4] = mask.right_ok;
    nb[5]    = mid_col_r.bot;
    nb_ok[5] = mask.left_ok & mask.bot_ok;
    nb[6]    = right_col_r.bot;
    nb_ok[6] = mask.bot_ok;
    nb[7]    = new_col.bot;
    nb_ok[7] = mask.right_ok & mask.bot_ok;
  end

  // sum the opaque, in-bounds neighbors
  always_comb begin
    res_nxt.sum_red   = '0;
    res_nxt.sum_green = '0;
    res_nxt.sum_blue  = '0;
    res_nxt.count     = '0;
    for (int i = 0; i < aed_pkg::NB_N; i++) begin
      if (nb_ok[i] && (nb[i].alpha > threshold)) begin
        res_nxt.sum_red   = res_nxt.sum_red + aed_pkg::SUM_W'(nb[i].red);
        res_nxt.sum_green = res_nxt.sum_green + aed_pkg::SUM_W'(nb[i].green);
        res_nxt.sum_blue  = res_nxt.sum_blue + aed_pkg::SUM_W'(nb[i].blue);
        res_nxt.count     = res_nxt.count + aed_pkg::CNT_W'(1);
      end
    end
    res_nxt.center = right_col_r.mid;
    res_nxt.fill   = (right_col_r.mid.alpha <= threshold) && (res_nxt.count != '0);
  end

  // column shift and result register
  always_ff @(posedge clk) begin
    if (step) begin
      mid_col_r   <= right_col_r;
      right_col_r <= new_col;
      res_r       <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

@@ rtl/aed_mean.sv @@
// neighbor mean by reciprocal multiply, or the center pixel unchanged
module aed_mean (
  input  aed_pkg::win_res_t res,
  output aed_pkg::pix_t     pix
);

  localparam int PROD_W = aed_pkg::SUM_W + aed_pkg::RECIP_W;

  logic [aed_pkg::RECIP_W-1:0] k;
  logic [PROD_W-1:0]           prod_red;
  logic [PROD_W-1:0]           prod_green;
  logic [PROD_W-1:0]           prod_blue;

  always_comb begin
    k          = aed_pkg::recip(res.count);
    prod_red   = PROD_W'(res.sum_red) * PROD_W'(k);
    prod_green = PROD_W'(res.sum_green) * PROD_W'(k);
    prod_blue  = PROD_W'(res.sum_blue) * PROD_W'(k);
    if (res.fill) begin
      pix.red   = prod_red[aed_pkg::RECIP_SH +: aed_pkg::CH_W];
      pix.green = prod_green[aed_pkg::RECIP_SH +: aed_pkg::CH_W];
      pix.blue  = prod_blue[aed_pkg::RECIP_SH +: aed_pkg::CH_W];
      pix.alpha = aed_pkg::ALPHA_FULL;
    end else begin
      pix = res.center;
    end
  end

endmodule

@@ rtl/alpha_edge_dilate_3x3_unit.sv @@
// One pass of 3x3 alpha-bleed dilation over an RGBA frame streamed in raster
// order. Each accepted beat passes accept and line memory read, then window
// evaluation and write-back, then, when it produces a result, mean and output
// load, which waits while the output register is full. The steps follow the
// read-modify-write of the single line memory, which holds the two rows
// above the incoming pixel, one item in flight at a time. A result waits in
// the output register so the next pixel is taken meanwhile. Results lag by
// one row plus one pixel: send width+1 flush beats after each frame. The
// final result carries frame_last and any_filled. Any register write
// restarts the frame position; the line memory needs no clearing after
// reset, since border masking never reads an entry not yet written.
module alpha_edge_dilate_3x3_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  aed_in_if.sink       in_bus,
  aed_out_if.source    out_bus,
  aed_cfg_if.sink      cfg_bus
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int EW    = (COL_W + 1 > aed_pkg::IMG_W_W) ? COL_W + 1 : aed_pkg::IMG_W_W;
  localparam logic [EW-1:0]    MAX_W_E    = EW'(MAX_WIDTH);
  localparam logic [COL_W-1:0] MAX_W_LAST = COL_W'(MAX_WIDTH - 1);

  // configuration
  logic [aed_pkg::IMG_W_W-1:0] image_width_r;
  logic [aed_pkg::IMG_H_W-1:0] image_height_r;
  logic [aed_pkg::CH_W-1:0]    alpha_threshold_r;
  logic                        cfg_wr;
  logic                        restart;

  // frame position and per-item state
  aed_pkg::aed_state_t         state_r, state_nxt;
  logic [COL_W-1:0]            col_r, col_nxt;
  logic [aed_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]            col_q_r;
  logic [aed_pkg::ROW_W-1:0]   row_q_r;
  aed_pkg::pix_t               pix_q_r;
  logic                        last_q_r;
  logic                        filled_seen_r, filled_seen_nxt;

  // derived geometry
  logic [EW-1:0]               w_ext;
  logic [COL_W-1:0]            width_last;
  logic [aed_pkg::IMG_H_W-1:0] height_last;

  // evaluation
  logic                        col_zero;
  logic [COL_W-1:0]            cx;
  logic [aed_pkg::ROW_W-1:0]   cy_ext;
  logic [aed_pkg::IMG_H_W-1:0] cy;
  logic                        has_res;
  logic                        is_last;
  aed_pkg::mask_t              mask;

  // control strobes
  logic                        in_acc;
  logic                        mem_we;
  logic                        win_step;
  logic                        out_load;

  // memory and datapath
  aed_pkg::line_t              line_rd;
  aed_pkg::line_t              line_wr;
  aed_pkg::col_t               new_col;
  aed_pkg::win_res_t           win_res;
  aed_pkg::pix_t               mean_pix;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  aed_pkg::pix_t               out_pix_r;
  logic                        out_filled_r;
  logic                        out_last_r;
  logic                        out_any_r;

  // register writes
  assign cfg_bus.ready = 1'b1;
  assign cfg_wr        = cfg_bus.valid && cfg_bus.ready;

  always_comb begin
    case (cfg_bus.index)
      aed_pkg::REG_IMAGE_WIDTH,
      aed_pkg::REG_IMAGE_HEIGHT,
      aed_pkg::REG_ALPHA_THRESHOLD: restart = cfg_wr;
      default:                      restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r     <= aed_pkg::WIDTH_RST;
      image_height_r    <= aed_pkg::HEIGHT_RST;
      alpha_threshold_r <= aed_pkg::THR_RST;
    end else if (cfg_wr) begin
      case (cfg_bus.index)
        aed_pkg::REG_IMAGE_WIDTH:     image_width_r <= cfg_bus.wdata[aed_pkg::IMG_W_W-1:0];
        aed_pkg::REG_IMAGE_HEIGHT:    image_height_r <= cfg_bus.wdata[aed_pkg::IMG_H_W-1:0];
        aed_pkg::REG_ALPHA_THRESHOLD: alpha_threshold_r <= cfg_bus.wdata[aed_pkg::CH_W-1:0];
        default: ;
      endcase
    end
  end

  // effective width (0 acts as 1, clamp at MAX_WIDTH) and height (0 acts as 1)
  always_comb begin
    w_ext = EW'(image_width_r);
    if (image_width_r == '0) begin
      width_last = '0;
    end else if (w_ext > MAX_W_E) begin
      width_last = MAX_W_LAST;
    end else begin
      width_last = COL_W'(w_ext - EW'(1));
    end
    height_last = (image_height_r == '0) ? '0 : image_height_r - aed_pkg::IMG_H_W'(1);
  end

  // window center and border masks for the item in evaluation
  always_comb begin
    col_zero = (col_q_r == '0);
    if (col_zero) begin
      cx     = width_last;
      cy_ext = row_q_r - aed_pkg::ROW_W'(2);
    end else begin
      cx     = col_q_r - COL_W'(1);
      cy_ext = row_q_r - aed_pkg::ROW_W'(1);
    end
    cy            = cy_ext[aed_pkg::IMG_H_W-1:0];
    has_res       = !((row_q_r == '0) || ((row_q_r == aed_pkg::ROW_W'(1)) && col_zero));
    mask.left_ok  = (cx != '0);
    mask.right_ok = (cx != width_last);
    mask.top_ok   = (cy != '0);
    mask.bot_ok   = (cy < height_last);
    is_last       = has_res && (cx == width_last) && (cy == height_last);
  end

  // sequencer: next state
  always_comb begin
    case (state_r)
      aed_pkg::ST_IDLE: state_nxt = in_acc ? aed_pkg::ST_EVAL : aed_pkg::ST_IDLE;
      aed_pkg::ST_EVAL: state_nxt = has_res ? aed_pkg::ST_MEAN : aed_pkg::ST_IDLE;
      aed_pkg::ST_MEAN: state_nxt = out_load ? aed_pkg::ST_IDLE : aed_pkg::ST_MEAN;
      default:          state_nxt = aed_pkg::ST_IDLE;
    endcase
  end

  // sequencer: strobes; memory write and the next read never share a cycle
  always_comb begin
    in_bus.ready = 1'b0;
    mem_we       = 1'b0;
    win_step     = 1'b0;
    out_load     = 1'b0;
    case (state_r)
      aed_pkg::ST_IDLE: in_bus.ready = 1'b1;
      aed_pkg::ST_EVAL: begin
        mem_we   = 1'b1;
        win_step = 1'b1;
      end
      aed_pkg::ST_MEAN: out_load = !out_valid_r || out_bus.ready;
      default: ;
    endcase
  end

  assign in_acc = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aed_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // frame position: advance on accept, clear at frame end or register write
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart || (win_step && is_last)) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_acc) begin
      if (col_r >= width_last) begin
        col_nxt = '0;
        row_nxt = row_r + aed_pkg::ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // item capture; a flush beat enters as a transparent pixel
  always_ff @(posedge clk) begin
    if (in_acc) begin
      col_q_r <= col_r;
      row_q_r <= row_r;
      if (in_bus.flush) begin
        pix_q_r <= '0;
      end else begin
        pix_q_r.red   <= in_bus.red;
        pix_q_r.green <= in_bus.green;
        pix_q_r.blue  <= in_bus.blue;
        pix_q_r.alpha <= in_bus.alpha;
      end
    end
    if (win_step) begin
      last_q_r <= is_last;
    end
  end

  // line memory: read at accept, rows shift down on write-back
  aed_line_ram #(
    .WIDTH ($bits(aed_pkg::line_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .rd_data (line_rd),
    .wr_en   (mem_we),
    .wr_addr (col_q_r),
    .wr_data (line_wr)
  );

  always_comb begin
    line_wr.upper  = line_rd.middle;
    line_wr.middle = pix_q_r;
    new_col.top    = line_rd.upper;
    new_col.mid    = line_rd.middle;
    new_col.bot    = pix_q_r;
  end

  aed_window u_window (
    .clk       (clk),
    .step      (win_step),
    .new_col   (new_col),
    .mask      (mask),
    .threshold (alpha_threshold_r),
    .res       (win_res)
  );

  aed_mean u_mean (
    .res (win_res),
    .pix (mean_pix)
  );

  // filled tracking across the frame
  always_comb begin
    filled_seen_nxt = filled_seen_r;
    if (restart) begin
      filled_seen_nxt = 1'b0;
    end else if (out_load) begin
      filled_seen_nxt = last_q_r ? 1'b0 : (filled_seen_r | win_res.fill);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_seen_r <= 1'b0;
    end else begin
      filled_seen_r <= filled_seen_nxt;
    end
  end

  // output register
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pix_r    <= mean_pix;
      out_filled_r <= win_res.fill;
      out_last_r   <= last_q_r;
      out_any_r    <= last_q_r && (filled_seen_r || win_res.fill);
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.out_red    = out_pix_r.red;
  assign out_bus.out_green  = out_pix_r.green;
  assign out_bus.out_blue   = out_pix_r.blue;
  assign out_bus.out_alpha  = out_pix_r.alpha;
  assign out_bus.filled     = out_filled_r;
  assign out_bus.frame_last = out_last_r;
  assign out_bus.any_filled = out_any_r;

  // checks
  ast_rmw_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && in_acc))
    else $error("line memory write-back overlaps a new read");

  ast_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (win_step && is_last) |=> ((col_r == '0) && (row_r == '0)))
    else $error("frame position not cleared after last pixel");

  ast_any_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.any_filled) |-> out_bus.frame_last)
    else $error("any_filled raised off the frame's last pixel");

  ast_fill_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.filled) |-> (out_bus.out_alpha == aed_pkg::ALPHA_FULL))
    else $error("filled pixel without full alpha");

endmodule
